>>> sv/tti_pkg.sv
// shared types, constants and interpolation tables for the thermistor interpolator
// no dependencies; imported by every module of the block
`default_nettype none

package tti_pkg;

    // table geometry
    localparam int STORED_PAIRS = 32;
    localparam int TABLE_PAIRS  = 32;
    localparam int USED_PAIRS   = (TABLE_PAIRS > STORED_PAIRS) ? STORED_PAIRS :
                                  ((TABLE_PAIRS < 2) ? 2 : TABLE_PAIRS);
    localparam int SEGS         = USED_PAIRS - 1;
    localparam int SEG_W        = (SEGS > 1) ? $clog2(SEGS) : 1;

    // field and datapath widths
    localparam int RAW_W       = 10;
    localparam int TEMP_W      = 10;
    localparam int OFF_W       = 7;    // widest segment span is 81 counts
    localparam int DEN_W       = 7;
    localparam int DT_W        = 9;    // widest temperature step is 413
    localparam int NUM_W       = 13;   // within a segment |dt| * offset stays below 8192
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int CHK_W       = Q_W + DEN_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ascending adc counts
    localparam logic [RAW_W-1:0] PT_COUNT [STORED_PAIRS] = '{
           1,   17,   20,   23,   27,   31,   37,   43,
          51,   61,   73,   87,  106,  128,  155,  189,
         230,  278,  336,  402,  476,  554,  635,  713,
         784,  846,  897,  937,  966,  986, 1000, 1010
    };

    // descending temperatures
    localparam logic [TEMP_W-1:0] PT_TEMP [STORED_PAIRS] = '{
         713,  300,  290,  280,  270,  260,  250,  240,
         230,  220,  210,  200,  190,  180,  170,  160,
         150,  140,  130,  120,  110,  100,   90,   80,
          70,   60,   50,   40,   30,   20,   10,    0
    };

    // per segment: count span
    localparam logic [DEN_W-1:0] PT_DEN [STORED_PAIRS-1] = '{
          16,    3,    3,    4,    4,    6,    6,    8,
          10,   12,   14,   19,   22,   27,   34,   41,
          48,   58,   66,   74,   78,   81,   78,   71,
          62,   51,   40,   29,   20,   14,   10
    };

    // per segment: temperature drop
    localparam logic [DT_W-1:0] PT_DT [STORED_PAIRS-1] = '{
         413,   10,   10,   10,   10,   10,   10,   10,
          10,   10,   10,   10,   10,   10,   10,   10,
          10,   10,   10,   10,   10,   10,   10,   10,
          10,   10,   10,   10,   10,   10,   10
    };

    // per segment: ceil(2^16 / span), quotient estimate is exact or one high
    localparam logic [RECIP_W-1:0] PT_RECIP [STORED_PAIRS-1] = '{
        4096, 21846, 21846, 16384, 16384, 10923, 10923, 8192,
        6554,  5462,  4682,  3450,  2979,  2428,  1928, 1599,
        1366,  1130,   993,   886,   841,   810,   841,  924,
        1058,  1286,  1639,  2260,  3277,  4682,  6554
    };

    localparam logic [RAW_W-1:0]  CNT_LO  = PT_COUNT[0];
    localparam logic [TEMP_W-1:0] TEMP_LO = PT_TEMP[0];
    localparam logic [RAW_W-1:0]  CNT_HI  = PT_COUNT[USED_PAIRS-1];
    localparam logic [TEMP_W-1:0] TEMP_HI = PT_TEMP[USED_PAIRS-1];

    typedef enum logic [1:0] {
        CLS_LOW,
        CLS_SEG,
        CLS_HIGH
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic [SEG_W-1:0]   seg;
        logic [RAW_W-1:0]   raw;
    } t_seg_item;

endpackage

`default_nettype wire

>>> sv/tti_front.sv
// front end: takes a raw count, classifies it and finds its table segment
// depends on tti_pkg
`default_nettype none

module tti_front
    import tti_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [RAW_W-1:0]  i_raw_count,
    output logic                   o_item_valid,
    input  wire logic              i_item_ready,
    output t_seg_item              o_item
);

    logic      r_valid;
    t_seg_item r_item;
    t_seg_item n_item;
    logic [SEG_W-1:0] seg;

    // segment index = number of interior points at or below the count
    always_comb begin
        seg = '0;
        for (int i = 1; i < SEGS; i++) begin
            seg = seg + SEG_W'(i_raw_count >= PT_COUNT[i]);
        end
        n_item.raw = i_raw_count;
        n_item.seg = seg;
        if (i_raw_count <= CNT_LO) begin
            n_item.cls = CLS_LOW;
        end else if (i_raw_count >= CNT_HI) begin
            n_item.cls = CLS_HIGH;
        end else begin
            n_item.cls = CLS_SEG;
        end
    end

    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/tti_queue.sv
// short fifo of classified beats between front and back
// depends on tti_pkg
`default_nettype none

module tti_queue
    import tti_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push_valid,
    output logic           o_push_ready,
    input  wire t_seg_item i_push_item,
    output logic           o_pop_valid,
    input  wire logic      i_pop_ready,
    output t_seg_item      o_pop_item
);

    t_seg_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                push;
    logic                pop;

    // full does not look at pop, keeps the ready path short
    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/tti_back.sv
// back end: three-stage interpolation pipeline with output register
// depends on tti_pkg
`default_nettype none

module tti_back
    import tti_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    output logic                    o_item_ready,
    input  wire t_seg_item          i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [TEMP_W-1:0]       o_temp_celsius
);

    // stage a: offset and |dt| * offset
    logic               r_va;
    t_cls               r_cls_a;
    logic [SEG_W-1:0]   r_seg_a;
    logic [NUM_W-1:0]   r_num_a;
    // stage b: reciprocal product
    logic               r_vb;
    t_cls               r_cls_b;
    logic [SEG_W-1:0]   r_seg_b;
    logic [NUM_W-1:0]   r_num_b;
    logic [PROD_W-1:0]  r_prod_b;
    // stage c: output register
    logic               r_vc;
    logic [TEMP_W-1:0]  r_temp_c;

    logic               adv_a;
    logic               adv_b;
    logic               adv_c;
    logic [RAW_W-1:0]   off_full;
    logic [OFF_W-1:0]   off;
    logic [DT_W+OFF_W-1:0] num_full;
    logic [PROD_W-1:0]  prod;
    logic [Q_W-1:0]     q_est;
    logic [CHK_W-1:0]   chk;
    logic [Q_W-1:0]     q_fix;
    logic [TEMP_W-1:0]  n_temp;

    assign adv_c        = !r_vc || i_ready;
    assign adv_b        = !r_vb || adv_c;
    assign adv_a        = !r_va || adv_b;
    assign o_item_ready = adv_a;
    assign o_valid      = r_vc;
    assign o_temp_celsius = r_temp_c;

    always_comb begin
        off_full = i_item.raw - PT_COUNT[i_item.seg];
        off      = off_full[OFF_W-1:0];
        num_full = PT_DT[i_item.seg] * off;
        prod     = r_num_a * PT_RECIP[r_seg_a];
    end

    // estimate is exact or one high, one compare fixes it
    always_comb begin
        q_est = r_prod_b[PROD_W-1:RECIP_SHIFT];
        chk   = q_est * PT_DEN[r_seg_b];
        q_fix = (chk > CHK_W'(r_num_b)) ? (q_est - 1'b1) : q_est;
        unique case (r_cls_b)
            CLS_LOW:  n_temp = TEMP_LO;
            CLS_SEG:  n_temp = PT_TEMP[r_seg_b] - TEMP_W'(q_fix);
            CLS_HIGH: n_temp = TEMP_HI;
            default:  n_temp = TEMP_HI;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (adv_a) begin
                r_va <= i_item_valid;
            end
            if (adv_b) begin
                r_vb <= r_va;
            end
            if (adv_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_item_valid) begin
            r_cls_a <= i_item.cls;
            r_seg_a <= i_item.seg;
            r_num_a <= num_full[NUM_W-1:0];
        end
        if (adv_b && r_va) begin
            r_cls_b  <= r_cls_a;
            r_seg_b  <= r_seg_a;
            r_num_b  <= r_num_a;
            r_prod_b <= prod;
        end
        if (adv_c && r_vb) begin
            r_temp_c <= n_temp;
        end
    end

endmodule

`default_nettype wire

>>> sv/thermistor_temp_interpolator.sv
// top level of the thermistor count to celsius interpolator
// depends on tti_pkg, tti_front, tti_queue, tti_back
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_raw_count    (10 bit unsigned adc count)
// output    out        o_valid / i_ready    o_temp_celsius (10 bit unsigned degrees)
//
// one beat per cycle sustained while the output is not stalled; an accepted count
// passes through the front register, a queue slot and three back stages before
// o_valid rises and the result can be taken
// the back pipeline is set by three narrow multiplies: |dt| * offset, then the
// reciprocal product, then a quotient check against the segment span
// reset is synchronous, active low, and clears only valid and pointer state
// a stall on the output fills the back stages, then the queue, then the front
// register before o_ready drops; each side stalls on its own
`default_nettype none

module thermistor_temp_interpolator
    import tti_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [RAW_W-1:0]   i_raw_count,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [TEMP_W-1:0]       o_temp_celsius
);

    // front to queue
    logic      front_valid;
    logic      front_ready;
    t_seg_item front_item;
    // queue to back
    logic      queue_valid;
    logic      queue_ready;
    t_seg_item queue_item;

    // classify the count and locate its segment
    tti_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_count  (i_raw_count),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    // decouples front and back stalls
    tti_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    // interpolate: t0 - floor(|dt| * offset / span), clamps at the table ends
    tti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (queue_valid),
        .o_item_ready   (queue_ready),
        .i_item         (queue_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_temp_celsius (o_temp_celsius)
    );

endmodule

`default_nettype wire

>>> bench/tti_temp_checker.sv
// checker for the thermistor interpolator: watches both channels, predicts and compares
// depends on tti_pkg for the field widths and the count / temperature table
`timescale 1ns / 1ps

module tti_temp_checker
    import tti_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [RAW_W-1:0]   i_raw_count,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [TEMP_W-1:0]  i_temp_celsius,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [RAW_W-1:0]   raw;
        logic [TEMP_W-1:0]  temp;
    } t_temp_due;

    t_temp_due temps_due[$];
    int        fails = 0;

    // piecewise-linear lookup, quotient truncated toward zero
    function automatic logic [TEMP_W-1:0] interp_temp(input logic [RAW_W-1:0] raw);
        int r0;
        int r1;
        int t0;
        int t1;
        int v;
        if (raw <= CNT_LO) return TEMP_LO;
        if (raw >= CNT_HI) return TEMP_HI;
        for (int k = 0; k + 1 < USED_PAIRS; k++) begin
            r0 = PT_COUNT[k];
            r1 = PT_COUNT[k+1];
            if (raw == r0) return PT_TEMP[k];
            if (raw > r0 && raw < r1) begin
                t0 = PT_TEMP[k];
                t1 = PT_TEMP[k+1];
                v  = t0 + ((t1 - t0) * (int'(raw) - r0)) / (r1 - r0);
                if (v < 0) v = 0;
                return v[TEMP_W-1:0];
            end
        end
        return TEMP_HI;
    endfunction

    always @(posedge i_clk) begin : check_beat
        t_temp_due want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (temps_due.size() == 0) begin
                    $display("%0t: unexpected temp beat: expected none, actual %0d",
                             $time, i_temp_celsius);
                    fails++;
                end else begin
                    want = temps_due.pop_front();
                    if (i_temp_celsius !== want.temp) begin
                        $display("%0t: temp for count %0d: expected %0d, actual %0d",
                                 $time, want.raw, want.temp, i_temp_celsius);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.raw  = i_raw_count;
                want.temp = interp_temp(i_raw_count);
                temps_due.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= temps_due.size();
    end

endmodule

>>> bench/tb.sv
// testbench top for thermistor_temp_interpolator: clock, reset, count stimulus, verdict
// depends on tti_pkg, the block and tti_temp_checker (prediction and comparison)
`timescale 1ns / 1ps

module tb;
    import tti_pkg::*;

    localparam int RANDOM_BEATS = 1600;
    localparam int LONG_HOLD    = 300;      // receiver hold-off, long enough to back up the input
    localparam int DRAIN_CYCLES = 20;       // extra wait after the final drain, leaves plenty of margin
    localparam int CYCLE_LIMIT  = 500000;   // hang guard bound, ends the run if it is reached

    // counts around the clamp points, exact table points, the widest segment
    // (554 to 635), the first one with the big temperature drop, and single high bits
    localparam int N_CORNERS = 24;
    localparam logic [RAW_W-1:0] CORNER_COUNTS [N_CORNERS] = '{
           0,    1,    2,    9,   16,   17,   18,   20,
          54,  512,  554,  555,  633,  713,  341,  985,
         986,  999, 1000, 1001, 1009, 1010, 1011, 1023
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [RAW_W-1:0]   raw_count;
    logic               out_valid;
    logic               out_ready;
    logic [TEMP_W-1:0]  temp_celsius;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idle stretches: each side flips between idling and back-to-back now and then
    bit send_idle_en  = 1'b1;
    int send_run_left = 40;
    bit recv_idle_en  = 1'b0;
    int recv_run_left = 25;
    bit long_hold_req = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    thermistor_temp_interpolator i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_raw_count    (raw_count),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_temp_celsius (temp_celsius)
    );

    tti_temp_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_raw_count    (raw_count),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_temp_celsius (temp_celsius),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // wait before the next beat; zero throughout a no-idle stretch
    task automatic draw_wait(inout bit idle_en, inout int run_left, output int gap);
        if (run_left == 0) begin
            idle_en  = !idle_en;
            run_left = $urandom_range(10, 80);
        end
        run_left--;
        gap = idle_en ? $urandom_range(0, 15) : 0;
    endtask

    // offer one count and return at the edge where it is taken;
    // valid stays up across back-to-back beats, only the payload moves
    task automatic offer_count(input logic [RAW_W-1:0] raw);
        int gap;
        draw_wait(send_idle_en, send_run_left, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_count <= raw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop offering and wait until every temp beat due has come back
    task automatic drain_temps();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls per beat, plus a long hold-off when asked
    initial begin
        int gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            draw_wait(recv_idle_en, recv_run_left, gap);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial begin
        int v;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        raw_count <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        foreach (CORNER_COUNTS[i]) offer_count(CORNER_COUNTS[i]);
        drain_temps();

        // random counts: half uniform, the rest near table points and both clamps
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 400 || n == 1200) long_hold_req = 1'b1;
            if (n == 800) drain_temps();
            case ($urandom_range(0, 7))
                0, 1, 2, 3: v = $urandom_range(0, 1023);
                4, 5: v = int'(PT_COUNT[$urandom_range(0, STORED_PAIRS - 1)])
                          + int'($urandom_range(0, 2)) - 1;
                6: v = $urandom_range(0, 20);
                default: v = $urandom_range(990, 1023);
            endcase
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            offer_count(v[RAW_W-1:0]);
        end

        drain_temps();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hang guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d temp beats still due", $time, pending);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

>>> sim.f
sv/tti_pkg.sv
sv/tti_front.sv
sv/tti_queue.sv
sv/tti_back.sv
sv/thermistor_temp_interpolator.sv
bench/tti_temp_checker.sv
bench/tb.sv
